@@ sv/line_position_pid_from_pixels_macros.svh @@
// Assertion macros shared by the line position PID blocks.
`ifndef LINE_POSITION_PID_FROM_PIXELS_MACROS_SVH
`define LINE_POSITION_PID_FROM_PIXELS_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define LPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define LPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lpp_pkg.sv @@
// Types, constants and helpers shared by the line position PID blocks.
package lpp_pkg;

  // Geometry
  localparam int ZONES       = 6;
  localparam int FRAME_WIDTH = 320;
  localparam int BAND_TOP    = 210;
  localparam int BAND_ROWS   = 30;
  localparam int ZONE_EDGE [ZONES] = '{60, 110, 160, 210, 260, FRAME_WIDTH};

  // Field widths
  localparam int COUNT_W  = 11;
  localparam int TOTAL_W  = 14;
  localparam int WPROD_W  = 23;
  localparam int NUM_W    = 26;
  localparam int DIVD_W   = 27;
  localparam int QUO_W    = 12;
  localparam int REM_W    = 15;
  localparam int SUM_W    = 24;
  localparam int DIFF_W   = 13;
  localparam int MULA_W   = 25;
  localparam int MULG_W   = 17;
  localparam int ACC_W    = 42;
  localparam int CFG_W    = 24;
  localparam int CIDX_W   = 3;
  localparam int CNT_W    = 4;

  localparam int ERR_MAX   = 3200;
  localparam int DIV_STEPS = QUO_W;
  localparam int PID_STEPS = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  // Register indexes on the config port
  localparam logic [CIDX_W-1:0] REG_LOWER  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_UPPER  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GAIN_P = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GAIN_I = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GAIN_D = 3'd4;

  localparam logic [CFG_W-1:0] LOWER_RESET  = 24'd0;
  localparam logic [CFG_W-1:0] UPPER_RESET  = 24'd11730553;
  localparam logic [15:0]      GAIN_P_RESET = 16'd6400;
  localparam logic [15:0]      GAIN_I_RESET = 16'd26;
  localparam logic [15:0]      GAIN_D_RESET = 16'd30720;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SETUP,
    ST_DIVIDE,
    ST_PREP,
    ST_PID,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_P,
    SEL_I,
    SEL_D
  } pid_sel_t;

  typedef struct packed {
    logic       count_en;
    logic       snap;
    logic       acc_step;
    logic [2:0] acc_idx;
    logic       div_init;
    logic       div_step;
    logic       prep;
    logic       mul_en;
    pid_sel_t   mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic out_free;
  } status_t;

  // Zone weight in tenths, offset by 1600 so it is never negative.
  function automatic logic [QUO_W-1:0] zone_weight(input logic [2:0] idx);
    logic [QUO_W-1:0] w;
    case (idx)
      3'd0:    w = 12'd3200;
      3'd1:    w = 12'd2667;
      3'd2:    w = 12'd2133;
      3'd3:    w = 12'd1067;
      3'd4:    w = 12'd533;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/lpp_ctrl.sv @@
// Frame controller: pixel intake, end-of-frame sequencing, result handoff.
`include "line_position_pid_from_pixels_macros.svh"
module lpp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            frame_last,
  output logic            in_stall,
  input  lpp_pkg::status_t status,
  output lpp_pkg::cmd_t    cmd
);
  import lpp_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (frame_last) begin
            cmd.snap   = 1'b1;
            cnt_next   = '0;
            state_next = ST_ACCUM;
          end else begin
            cmd.count_en = 1'b1;
          end
        end
      end
      ST_ACCUM: begin
        cmd.acc_step = 1'b1;
        cmd.acc_idx  = cnt[2:0];
        if (cnt == CNT_W'(ZONES - 1)) begin
          cnt_next   = '0;
          state_next = ST_SETUP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SETUP: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = status.total_zero ? ST_FIN : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_PREP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_PID;
      end
      ST_PID: begin
        // one product per cycle, each registered and then summed into the accumulator
        case (cnt[1:0])
          2'd0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_P;
            cmd.acc_clr = 1'b1;
          end
          2'd1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_I;
            cmd.acc_add = 1'b1;
          end
          2'd2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_D;
            cmd.acc_add = 1'b1;
          end
          default: begin
            cmd.acc_add = 1'b1;
          end
        endcase
        if (cnt == CNT_W'(PID_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `LPP_ASSERT_NEXT(a_fin_leaves, state == ST_FIN && status.out_free, state == ST_IDLE, "result load did not return to idle")
  `LPP_ASSERT_IMP(a_div_len, state == ST_DIVIDE, cnt <= CNT_W'(DIV_STEPS - 1), "divide ran past its step count")
  `LPP_ASSERT_NEXT(a_snap_busy, cmd.snap, state == ST_ACCUM && in_stall, "frame end did not start accumulation")

endmodule

@@ sv/lpp_datapath.sv @@
// Datapath: pixel match and zone counters, weighted sum, divider, PID, result register.
`include "line_position_pid_from_pixels_macros.svh"
module lpp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lpp_pkg::cmd_t                        cmd,
  output lpp_pkg::status_t                     status,
  input  logic                                cfg_write,
  input  logic [lpp_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [lpp_pkg::CFG_W-1:0]           cfg_data,
  input  logic [7:0]                          hue,
  input  logic [7:0]                          saturation,
  input  logic [7:0]                          brightness,
  input  logic [8:0]                          column,
  input  logic [7:0]                          row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpp_pkg::COUNT_W-1:0]         zone0_count,
  output logic [lpp_pkg::COUNT_W-1:0]         zone1_count,
  output logic [lpp_pkg::COUNT_W-1:0]         zone2_count,
  output logic [lpp_pkg::COUNT_W-1:0]         zone3_count,
  output logic [lpp_pkg::COUNT_W-1:0]         zone4_count,
  output logic [lpp_pkg::COUNT_W-1:0]         zone5_count,
  output logic [lpp_pkg::QUO_W-1:0]           line_error,
  output logic signed [31:0]                  drive,
  output logic                                no_line
);
  import lpp_pkg::*;

  // config registers
  logic [CFG_W-1:0] lower_limits, upper_limits;
  logic [15:0]      gain_p, gain_i, gain_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limits <= LOWER_RESET;
      upper_limits <= UPPER_RESET;
      gain_p       <= GAIN_P_RESET;
      gain_i       <= GAIN_I_RESET;
      gain_d       <= GAIN_D_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOWER:  lower_limits <= cfg_data;
        REG_UPPER:  upper_limits <= cfg_data;
        REG_GAIN_P: gain_p       <= cfg_data[15:0];
        REG_GAIN_I: gain_i       <= cfg_data[15:0];
        REG_GAIN_D: gain_d       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pixel match
  logic       color_ok, band_ok, pix_match;
  logic [8:0] row_off;

  assign color_ok = hue >= lower_limits[23:16] && hue <= upper_limits[23:16] &&
                    saturation >= lower_limits[15:8] && saturation <= upper_limits[15:8] &&
                    brightness >= lower_limits[7:0] && brightness <= upper_limits[7:0];
  assign row_off   = {1'b0, row} - 9'(BAND_TOP);
  assign band_ok   = {1'b0, row} >= 9'(BAND_TOP) && row_off < 9'(BAND_ROWS);
  assign pix_match = color_ok && band_ok;

  // zone counters, one lane per zone
  logic [COUNT_W-1:0] count     [ZONES];
  logic [COUNT_W-1:0] count_inc [ZONES];
  logic [COUNT_W-1:0] snap      [ZONES];

  for (genvar k = 0; k < ZONES; k++) begin : g_zone
    logic hit;
    if (k == 0) begin : g_first
      assign hit = column < 9'(ZONE_EDGE[0]);
    end else begin : g_rest
      assign hit = column >= 9'(ZONE_EDGE[k-1]) && column < 9'(ZONE_EDGE[k]);
    end
    assign count_inc[k] = (pix_match && hit && count[k] != COUNT_MAX) ?
                          count[k] + 1'b1 : count[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        count[k] <= '0;
      end else if (cmd.snap) begin
        count[k] <= '0;
      end else if (cmd.count_en) begin
        count[k] <= count_inc[k];
      end
    end

    // snapshot rotates once per accumulate step; six steps restore order
    always_ff @(posedge clk) begin
      if (cmd.snap) begin
        snap[k] <= count_inc[k];
      end else if (cmd.acc_step) begin
        snap[k] <= snap[(k + 1) % ZONES];
      end
    end
  end

  // weighted sum and total
  logic [NUM_W-1:0]   num;
  logic [TOTAL_W-1:0] total;
  logic [WPROD_W-1:0] wprod;

  assign wprod = snap[0] * zone_weight(cmd.acc_idx);

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      num   <= '0;
      total <= '0;
    end else if (cmd.acc_step) begin
      num   <= num + NUM_W'(wprod);
      total <= total + TOTAL_W'(snap[0]);
    end
  end

  // rounded divide: (2*num + total) / (2*total), one quotient bit per cycle
  logic [DIVD_W-1:0]  dividend;
  logic [REM_W-1:0]   rem, dvs;
  logic [QUO_W-1:0]   quo;
  logic [REM_W:0]     trial;
  logic               trial_ge;
  logic               no_line_r;

  assign dividend = {num, 1'b0} + DIVD_W'(total);
  assign trial    = {rem, quo[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem       <= dividend[DIVD_W-1:QUO_W];
      quo       <= dividend[QUO_W-1:0];
      dvs       <= {total, 1'b0};
      no_line_r <= total == '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? REM_W'(trial - {1'b0, dvs}) : trial[REM_W-1:0];
      quo <= {quo[QUO_W-2:0], trial_ge};
    end
  end

  // PID state update
  logic [QUO_W-1:0]         err, err_c, last_error;
  logic [SUM_W-1:0]         error_sum;
  logic [SUM_W:0]           sum_w;
  logic signed [DIFF_W-1:0] dval;

  assign err_c = (quo > QUO_W'(ERR_MAX)) ? QUO_W'(ERR_MAX) : quo;
  assign sum_w = {1'b0, error_sum} + (SUM_W + 1)'(err_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (cmd.prep) begin
      error_sum  <= sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
      last_error <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      err  <= err_c;
      dval <= $signed({1'b0, err_c}) - $signed({1'b0, last_error});
    end
  end

  // shared multiplier, product registered before the accumulator
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULG_W-1:0] mul_g;
  logic signed [ACC_W-1:0]  prod, acc;

  always_comb begin
    case (cmd.mul_sel)
      SEL_P: begin
        mul_a = $signed({{(MULA_W - QUO_W){1'b0}}, err});
        mul_g = $signed({1'b0, gain_p});
      end
      SEL_I: begin
        mul_a = $signed({1'b0, error_sum});
        mul_g = $signed({1'b0, gain_i});
      end
      SEL_D: begin
        mul_a = MULA_W'(dval);
        mul_g = $signed({1'b0, gain_d});
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_g;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end
  end

  // divide by 256, halves up, saturate to 32 bits
  localparam logic signed [ACC_W-9:0] DRV_MAX = 34'sd2147483647;
  localparam logic signed [ACC_W-9:0] DRV_MIN = -34'sd2147483648;

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-9:0] acc_shr;
  logic signed [31:0]      drv_sat;

  assign acc_rnd = acc + ACC_W'(128);
  assign acc_shr = acc_rnd[ACC_W-1:8];

  always_comb begin
    if (acc_shr > DRV_MAX) begin
      drv_sat = 32'sh7FFF_FFFF;
    end else if (acc_shr < DRV_MIN) begin
      drv_sat = 32'sh8000_0000;
    end else begin
      drv_sat = acc_shr[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      zone0_count <= snap[0];
      zone1_count <= snap[1];
      zone2_count <= snap[2];
      zone3_count <= snap[3];
      zone4_count <= snap[4];
      zone5_count <= snap[5];
      line_error  <= no_line_r ? '0 : err;
      drive       <= no_line_r ? '0 : drv_sat;
      no_line     <= no_line_r;
    end
  end

  assign status.total_zero = total == '0;
  assign status.out_free   = !out_valid || !out_stall;

  `LPP_ASSERT_IMP(a_quo_range, cmd.prep, quo <= QUO_W'(ERR_MAX), "line error quotient out of range")
  `LPP_ASSERT_IMP(a_noline_zero, out_valid && no_line, line_error == '0 && drive == '0, "no_line result carries data")
  `LPP_ASSERT_NEXT(a_counts_cleared, cmd.snap, (count[0] | count[1] | count[2] | count[3] | count[4] | count[5]) == '0, "zone counts not cleared at frame end")

endmodule

@@ sv/line_position_pid_from_pixels.sv @@
// Top level: line position and PID drive from a stream of HSV pixels.
//
// Input channel (in_valid / in_stall): one HSV pixel per beat with its column
// and row; frame_last marks the last pixel of a frame. Pixels are taken one
// per clock while the block is counting.
// Output channel (out_valid / out_stall): one beat per frame with the six zone
// counts, line_error, drive and no_line.
// End of frame: the frame_last beat is counted, then the end-of-frame pass
// runs the weighted sum (one zone at a time), a setup step, the divider (one
// quotient bit at a time), the PID state update, the products through the
// shared multiplier and the load; when the band is empty it goes from setup
// straight to the load. in_stall is high for that pass.
// The result sits in an output register; new pixels are counted while it
// waits. If it is still stalled at the next frame end, the pass holds in its
// load step, with in_stall high, until the receiver takes it.
// Reset (rst, synchronous): counts, PID integral and previous error clear,
// limits and gains return to their defaults, no result is pending.
// Config: cfg_write with cfg_index 0..4 writes lower_limits, upper_limits,
// gain_p, gain_i, gain_d from cfg_data; other indexes are ignored.
module line_position_pid_from_pixels (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lpp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lpp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  hue,
  input  logic [7:0]                  saturation,
  input  logic [7:0]                  brightness,
  input  logic [8:0]                  column,
  input  logic [7:0]                  row,
  input  logic                        frame_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lpp_pkg::COUNT_W-1:0] zone0_count,
  output logic [lpp_pkg::COUNT_W-1:0] zone1_count,
  output logic [lpp_pkg::COUNT_W-1:0] zone2_count,
  output logic [lpp_pkg::COUNT_W-1:0] zone3_count,
  output logic [lpp_pkg::COUNT_W-1:0] zone4_count,
  output logic [lpp_pkg::COUNT_W-1:0] zone5_count,
  output logic [lpp_pkg::QUO_W-1:0]   line_error,
  output logic signed [31:0]          drive,
  output logic                        no_line
);
  import lpp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: intake, accumulate, divide, PID, result handoff
  lpp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .frame_last (frame_last),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // counters, arithmetic and the result register
  lpp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .column      (column),
    .row         (row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .zone0_count (zone0_count),
    .zone1_count (zone1_count),
    .zone2_count (zone2_count),
    .zone3_count (zone3_count),
    .zone4_count (zone4_count),
    .zone5_count (zone5_count),
    .line_error  (line_error),
    .drive       (drive),
    .no_line     (no_line)
  );

endmodule
